>>> rtl/bc1_block_decoder_core_defines.svh
// Assertion macros shared by the BC1 block decoder RTL.
`ifndef BC1_BLOCK_DECODER_CORE_DEFINES_SVH
`define BC1_BLOCK_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BC1_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define BC1_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BC1_ASSERT_IMP(label, ante, cons, msg)
`define BC1_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/bc1_pkg.sv
// Types, constants and helper functions for the BC1 block decoder.
`timescale 1ns / 1ps

package bc1_pkg;

	localparam int unsigned PIXELS    = 16;
	localparam int unsigned CNT_W     = 4;
	localparam int unsigned CHAN_W    = 6;
	// floor(x / 3) == (x * 171) >> 9 holds for every x below 512.
	localparam logic [7:0]  RECIP3    = 8'd171;
	localparam int unsigned RECIP_SH  = 9;
	localparam logic [CNT_W-1:0] LAST_PIX = CNT_W'(PIXELS - 1);

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              a;
	} rgb_t;

	function automatic rgb_t expand565(input logic [15:0] v);
		rgb_t c;
		c.r = {v[15:11], 1'b0};
		c.g = v[10:5];
		c.b = {v[4:0], 1'b0};
		c.a = 1'b1;
		return c;
	endfunction

	// Weighted two-thirds blend of one channel, exact floor division by three.
	function automatic logic [CHAN_W-1:0] third_mix(input logic [CHAN_W-1:0] near_v,
			input logic [CHAN_W-1:0] far_v);
		logic [7:0]  sum;
		logic [15:0] prod;
		sum  = {1'b0, near_v, 1'b0} + {2'b00, far_v};
		prod = {8'd0, sum} * {8'd0, RECIP3};
		return prod[RECIP_SH +: CHAN_W];
	endfunction

	function automatic logic [CHAN_W-1:0] half_mix(input logic [CHAN_W-1:0] a_v,
			input logic [CHAN_W-1:0] b_v);
		logic [CHAN_W:0] sum;
		sum = {1'b0, a_v} + {1'b0, b_v};
		return sum[CHAN_W:1];
	endfunction

endpackage

>>> rtl/bc1_block_decoder_core.sv
// Top level of the BC1 block decoder: one block in, sixteen pixels out.
//
// Channel | Handshake          | Payload
// blk     | blk_valid/blk_stall | block_word[63:0]
// pix     | pix_valid/pix_stall | pixel_row, pixel_col, red, green, blue, opaque, last
//
// A block is held in one input register and emits one pixel per cycle while the
// pixel side does not stall; the sixteen-step pixel counter picks each pixel in turn.
// The next block is taken on the same edge that moves the last pixel out, so
// blocks stream with no gap. Palette and index selection sit between the input
// register and the output register. Reset clears only the valid flags and the
// counter. A stall on the pixel side holds the output register and the counter.
`timescale 1ns / 1ps

`include "bc1_block_decoder_core_defines.svh"

module bc1_block_decoder_core
	import bc1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        blk_valid,
	output logic        blk_stall,
	input  logic [63:0] block_word,
	output logic        pix_valid,
	input  logic        pix_stall,
	output logic [1:0]  pixel_row,
	output logic [1:0]  pixel_col,
	output logic [5:0]  red,
	output logic [5:0]  green,
	output logic [5:0]  blue,
	output logic        opaque,
	output logic        last
);

	logic [63:0]      word_s1;
	logic             valid_s1;
	logic [CNT_W-1:0] cnt_q;

	logic             out_valid_q;
	logic [1:0]       row_q;
	logic [1:0]       col_q;
	rgb_t             pix_q;
	logic             last_q;

	logic             advance;
	logic             emit;
	logic             blk_take;
	logic [15:0]      c0;
	logic [15:0]      c1;
	rgb_t             col0;
	rgb_t             col1;
	logic [1:0]       sel;
	logic [31:0]      idx_bits;
	rgb_t             pick;

	assign advance   = !out_valid_q || !pix_stall;
	assign emit      = advance && valid_s1;
	assign blk_stall = valid_s1 && !(emit && (cnt_q == LAST_PIX));
	assign blk_take  = blk_valid && !blk_stall;

	assign c0       = word_s1[15:0];
	assign c1       = word_s1[31:16];
	assign col0     = expand565(c0);
	assign col1     = expand565(c1);
	assign idx_bits = word_s1[63:32];
	assign sel      = idx_bits[{cnt_q, 1'b0} +: 2];

	// Only the palette entry that this pixel selects is built.
	always_comb begin
		pick = col0;
		case (sel)
			2'd0: pick = col0;
			2'd1: pick = col1;
			2'd2: begin
				if (c0 > c1) begin
					pick.r = third_mix(col0.r, col1.r);
					pick.g = third_mix(col0.g, col1.g);
					pick.b = third_mix(col0.b, col1.b);
				end else begin
					pick.r = half_mix(col0.r, col1.r);
					pick.g = half_mix(col0.g, col1.g);
					pick.b = half_mix(col0.b, col1.b);
				end
				pick.a = 1'b1;
			end
			default: begin
				if (c0 > c1) begin
					pick.r = third_mix(col1.r, col0.r);
					pick.g = third_mix(col1.g, col0.g);
					pick.b = third_mix(col1.b, col0.b);
					pick.a = 1'b1;
				end else begin
					pick = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (blk_take) begin
			valid_s1 <= 1'b1;
			cnt_q    <= '0;
		end else if (emit) begin
			if (cnt_q == LAST_PIX) begin
				valid_s1 <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (blk_take) begin
			word_s1 <= block_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_q  <= cnt_q[3:2];
			col_q  <= cnt_q[1:0];
			pix_q  <= pick;
			last_q <= (cnt_q == LAST_PIX);
		end
	end

	assign pix_valid = out_valid_q;
	assign pixel_row = row_q;
	assign pixel_col = col_q;
	assign red       = pix_q.r;
	assign green     = pix_q.g;
	assign blue      = pix_q.b;
	assign opaque    = pix_q.a;
	assign last      = last_q;

	`BC1_ASSERT_IMP(a_last_corner, pix_valid && last, (pixel_row == 2'd3) && (pixel_col == 2'd3), "last pixel is not the bottom right corner")
	`BC1_ASSERT_IMP(a_clear_black, pix_valid && !opaque, (red == '0) && (green == '0) && (blue == '0), "transparent pixel carries color")
	`BC1_ASSERT_IMP(a_take_on_last, blk_take && valid_s1, cnt_q == LAST_PIX, "new block request taken while pixels remain")
	`BC1_ASSERT_NEXT(a_no_gap, pix_valid && !pix_stall && !last, pix_valid, "pixel stream of a block has a gap")

endmodule

>>> test/tb.sv
// Self-checking testbench for the BC1 block decoder core: directed and random blocks.
`timescale 1ns / 1ps

module tb;
	import bc1_pkg::*;

	localparam int unsigned RANDOM_BLOCKS = 460;
	localparam int unsigned CALM_BLOCKS   = 60;
	localparam int unsigned IDLE_LIMIT    = 1000;
	localparam int unsigned DRAIN_CYCLES  = 40;
	localparam int unsigned DIRECTED_ROWS = 20;

	typedef struct packed {
		logic [5:0] r;
		logic [5:0] g;
		logic [5:0] b;
		logic       a;
	} swatch_t;

	typedef swatch_t [3:0] palette_t;

	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
		swatch_t    colour;
		logic       last;
	} pixel_t;

	// A row with typed set carries the one colour that every pixel of the block shows.
	typedef struct packed {
		logic [63:0] word;
		logic        typed;
		swatch_t     colour;
	} directed_t;

	localparam directed_t DIRECTED [0:DIRECTED_ROWS-1] = '{
		'{64'h0000_0000_0000_0000, 1'b1, '{6'd0,  6'd0,  6'd0,  1'b1}},
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'h0000_0000_0000_FFFF, 1'b1, '{6'd62, 6'd63, 6'd62, 1'b1}},
		'{64'h5555_5555_0000_FFFF, 1'b1, '{6'd0,  6'd0,  6'd0,  1'b1}},
		'{64'hAAAA_AAAA_0000_FFFF, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hFFFF_FFFF_0000_FFFF, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hAAAA_AAAA_FFFF_0000, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hFFFF_FFFF_FFFF_0000, 1'b1, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'h5555_5555_FFFF_0000, 1'b1, '{6'd62, 6'd63, 6'd62, 1'b1}},
		'{64'hE4E4_E4E4_1234_5678, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'h1B1B_1B1B_5678_1234, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hAAAA_AAAA_A5A5_A5A5, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hFFFF_FFFF_A5A5_A5A5, 1'b1, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hE4E4_E4E4_1234_1235, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hE4E4_E4E4_1235_1234, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hE4E4_E4E4_0000_F800, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hE4E4_E4E4_07E0_001F, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hE4E4_E4E4_001F_07E0, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'hAAAA_AAAA_0001_FFFE, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}},
		'{64'h0123_4567_89AB_CDEF, 1'b0, '{6'd0,  6'd0,  6'd0,  1'b0}}
	};

	logic        clk;
	logic        arst_n;
	logic        blk_valid;
	logic        blk_stall;
	logic [63:0] block_word;
	logic        pix_valid;
	logic        pix_stall;
	logic [1:0]  pixel_row;
	logic [1:0]  pixel_col;
	logic [5:0]  red;
	logic [5:0]  green;
	logic [5:0]  blue;
	logic        opaque;
	logic        last;

	pixel_t      pending_pixels [$];
	int unsigned errors = 0;
	bit          calm   = 1'b0;

	bc1_block_decoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_valid  (blk_valid),
		.blk_stall  (blk_stall),
		.block_word (block_word),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pixel_row  (pixel_row),
		.pixel_col  (pixel_col),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.opaque     (opaque),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Weighted floor average: ((div - 1) * heavy + light) / div.
	function automatic logic [5:0] weigh(input int unsigned heavy, input int unsigned light,
			input int unsigned div);
		return 6'(((div - 1) * heavy + light) / div);
	endfunction

	function automatic palette_t derive_palette(input logic [63:0] w);
		palette_t    p;
		logic [15:0] c0;
		logic [15:0] c1;
		c0 = w[15:0];
		c1 = w[31:16];
		p[0] = '{{c0[15:11], 1'b0}, c0[10:5], {c0[4:0], 1'b0}, 1'b1};
		p[1] = '{{c1[15:11], 1'b0}, c1[10:5], {c1[4:0], 1'b0}, 1'b1};
		if (c0 > c1) begin
			p[2] = '{weigh(p[0].r, p[1].r, 3), weigh(p[0].g, p[1].g, 3),
				weigh(p[0].b, p[1].b, 3), 1'b1};
			p[3] = '{weigh(p[1].r, p[0].r, 3), weigh(p[1].g, p[0].g, 3),
				weigh(p[1].b, p[0].b, 3), 1'b1};
		end else begin
			p[2] = '{weigh(p[0].r, p[1].r, 2), weigh(p[0].g, p[1].g, 2),
				weigh(p[0].b, p[1].b, 2), 1'b1};
			p[3] = '{6'd0, 6'd0, 6'd0, 1'b0};
		end
		return p;
	endfunction

	function automatic void queue_pixels(input logic [63:0] w, input palette_t p);
		pixel_t px;
		int     n;
		for (n = 0; n < PIXELS; n++) begin
			px.row    = 2'(n >> 2);
			px.col    = 2'(n);
			px.colour = p[w[32 + 2 * n +: 2]];
			px.last   = (n == PIXELS - 1);
			pending_pixels.push_back(px);
		end
	endfunction

	// Colour pairs lean toward the compare boundary and the extremes.
	function automatic logic [63:0] random_block();
		logic [15:0] c0;
		logic [15:0] c1;
		logic [15:0] swap;
		logic [31:0] idx;
		c0 = 16'($urandom);
		case ($urandom_range(0, 7))
			0: begin
				c1 = c0;
			end
			1: begin
				c1 = c0 + 16'd1;
			end
			2: begin
				c1 = c0 - 16'd1;
			end
			3: begin
				c1 = 16'h0000;
			end
			4: begin
				c1 = 16'hFFFF;
			end
			default: begin
				c1 = 16'($urandom);
			end
		endcase
		if ($urandom_range(0, 1) == 1) begin
			swap = c0;
			c0   = c1;
			c1   = swap;
		end
		idx = $urandom;
		if ($urandom_range(0, 9) == 0)
			idx = {16{idx[1:0]}};
		return {idx, c1, c0};
	endfunction

	task automatic send_block(input logic [63:0] w, input palette_t p);
		if (!calm && $urandom_range(0, 3) == 0) begin
			blk_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		blk_valid  <= 1'b1;
		block_word <= w;
		@(posedge clk);
		while (blk_stall !== 1'b0) @(posedge clk);
		queue_pixels(w, p);
	endtask

	task automatic hold_until_drained();
		blk_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	initial begin
		int unsigned i;
		logic [63:0] w;
		palette_t    p;
		blk_valid  <= 1'b0;
		block_word <= 64'd0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		for (i = 0; i < DIRECTED_ROWS; i++) begin
			p = DIRECTED[i].typed ? {4{DIRECTED[i].colour}} : derive_palette(DIRECTED[i].word);
			send_block(DIRECTED[i].word, p);
		end
		hold_until_drained();
		for (i = 0; i < RANDOM_BLOCKS; i++) begin
			if (i == RANDOM_BLOCKS / 2)
				hold_until_drained();
			if (i == RANDOM_BLOCKS - CALM_BLOCKS)
				calm = 1'b1;
			w = random_block();
			send_block(w, derive_palette(w));
		end
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Output stall comes in short bursts, separated by runs that are sometimes long.
	initial begin
		int unsigned run;
		pix_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
			repeat (run) @(posedge clk);
			if (!calm) begin
				pix_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				pix_stall <= 1'b0;
			end
		end
	end

	task automatic report_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_pixels
		pixel_t      seen;
		pixel_t      want;
		int unsigned idle_cycles;
		if (arst_n === 1'b1) begin
			if ((blk_valid === 1'b1 && blk_stall === 1'b0) ||
					(pix_valid === 1'b1 && pix_stall === 1'b0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb failed");
				$finish;
			end
			if (pix_valid === 1'b1 && pix_stall === 1'b0) begin
				seen = '{pixel_row, pixel_col, '{red, green, blue, opaque}, last};
				if (pending_pixels.size() == 0) begin
					$display("%0t: pixel with no request outstanding, expected none, actual %h",
						$time, seen);
					errors++;
				end else begin
					want = pending_pixels.pop_front();
					report_field("pixel_row", want.row, seen.row);
					report_field("pixel_col", want.col, seen.col);
					report_field("red", want.colour.r, seen.colour.r);
					report_field("green", want.colour.g, seen.colour.g);
					report_field("blue", want.colour.b, seen.colour.b);
					report_field("opaque", want.colour.a, seen.colour.a);
					report_field("last", want.last, seen.last);
				end
			end
		end else begin
			idle_cycles = 0;
		end
	end

endmodule
